FILE: hw/rtl/sid_pkg.sv
// Shared types and constants for the slot ID allocator.
// Used by every RTL file of the block but sid_ram; depends on nothing else.
package sid_pkg;

    localparam int unsigned SLOTS_DEF = 256;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_MISS = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] component_handle;
        logic [31:0] entity_handle;
        logic [7:0]  slot_id;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic        found;
        logic [7:0]  result_id;
        logic [31:0] result_component;
    } t_res;

    typedef struct packed {
        logic        live;
        logic [31:0] entity;
        logic [31:0] component;
    } t_slot;

endpackage

FILE: hw/rtl/slot_id_allocator_with_lookup.sv
// Slot ID allocator with lookup by entity: stream ports and output register.
// Depends on sid_pkg and sid_ctrl.
//
// A request enters on the s_axis channel; tuser carries the command and tdata
// carries the component handle, the entity handle and the slot ID. Every
// request yields exactly one response on the m_axis channel, with the status
// and found flag in tuser and the slot ID and component handle in tdata.
// Requests are handled one at a time by a sequencer around the slot memory
// and the free-list memory, both with a registered read port.
// An add with a fresh ID, an add to a full table and a clear go straight to
// the response; an add that reuses a freed ID and a remove of an ID handed out
// since the last clear first do one memory read before the write-back, while a
// remove of any other ID goes straight to the response. A find reads one slot
// per cycle from the slot memory until the first match, reading at most the
// number of IDs handed out since the last clear.
// The response sits in an output register, so the next request is taken while
// an earlier response is still held by a stalled receiver; a further response
// then waits in the sequencer and blocks new requests until the register
// frees up. Reset empties the free list and the table with no clearing pass and
// drops any response not yet taken; a clear command empties both the same way.
module slot_id_allocator_with_lookup #(
    parameter int unsigned SLOTS = sid_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // component_handle, entity_handle, slot_id
    input  logic [1:0]  s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // result_id, result_component
    output logic [2:0]  m_axis_tuser   // status, found
);

    sid_pkg::t_req req;
    sid_pkg::t_res res;
    sid_pkg::t_res r_out;
    logic          req_ready, res_valid, res_ready, r_out_valid;

    assign req.cmd              = sid_pkg::t_cmd'(s_axis_tuser);
    assign req.component_handle = s_axis_tdata[31:0];
    assign req.entity_handle    = s_axis_tdata[63:32];
    assign req.slot_id          = s_axis_tdata[71:64];

    sid_ctrl #(.SLOTS(SLOTS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_req_valid (s_axis_tvalid && s_axis_tready),
        .o_req_ready (req_ready),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready)
    );

    assign s_axis_tready = req_ready && i_rst_n;
    assign res_ready     = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.result_component, r_out.result_id};
    assign m_axis_tuser  = {r_out.found, r_out.status};

endmodule

FILE: hw/rtl/sid_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
// Generic storage used by the allocator engine; no package dependency.
module sid_ram #(
    parameter int unsigned W = 8,
    parameter int unsigned D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

FILE: hw/rtl/sid_ctrl.sv
// Allocator engine: sequencer, free-list pointers and the two state memories.
// Depends on sid_pkg and sid_ram.
module sid_ctrl #(
    parameter int unsigned SLOTS = sid_pkg::SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sid_pkg::t_req i_req,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    output sid_pkg::t_res o_res,
    output logic          o_res_valid,
    input  logic          i_res_ready
);

    localparam int unsigned IW = $clog2(SLOTS);
    localparam int unsigned CW = IW + 1;
    localparam int unsigned MW = (CW > 8) ? CW : 8;
    localparam int unsigned SW = $bits(sid_pkg::t_slot);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ADDQ = 5'b00010,
        S_REM  = 5'b00100,
        S_FIND = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_fresh, n_fresh;
    logic [IW-1:0] r_scan, n_scan;
    sid_pkg::t_req r_req;
    sid_pkg::t_res r_res, n_res;

    logic          slot_we, slot_re, fq_we, fq_re;
    logic [IW-1:0] slot_waddr, slot_raddr, fq_waddr, fq_raddr;
    sid_pkg::t_slot slot_wdata, slot_rdata;
    logic [SW-1:0] slot_rbits;
    logic [IW-1:0] fq_wdata, fq_rdata;

    sid_ram #(.W(SW), .D(SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_re    (slot_re),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rbits)
    );

    sid_ram #(.W(IW), .D(SLOTS)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (fq_we),
        .i_waddr (fq_waddr),
        .i_wdata (fq_wdata),
        .i_re    (fq_re),
        .i_raddr (fq_raddr),
        .o_rdata (fq_rdata)
    );

    assign slot_rdata  = sid_pkg::t_slot'(slot_rbits);
    assign o_req_ready = (r_state == S_IDLE);
    assign o_res       = r_res;
    assign o_res_valid = (r_state == S_DONE);

    // Slots at or above the fresh count have never been written since the
    // last clear, so they read as free without touching the memory.
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_fresh    = r_fresh;
        n_scan     = r_scan;
        n_res      = r_res;
        slot_we    = 1'b0;
        slot_re    = 1'b0;
        slot_waddr = '0;
        slot_raddr = '0;
        slot_wdata = '0;
        fq_we      = 1'b0;
        fq_re      = 1'b0;
        fq_waddr   = r_tail;
        fq_raddr   = r_head;
        fq_wdata   = IW'(r_req.slot_id);
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_res = '0;
                    unique case (i_req.cmd)
                        sid_pkg::CMD_ADD: begin
                            if (r_count != '0) begin
                                fq_re   = 1'b1;
                                n_state = S_ADDQ;
                            end else if (r_fresh < CW'(SLOTS)) begin
                                slot_we    = 1'b1;
                                slot_waddr = IW'(r_fresh);
                                slot_wdata = {1'b1, i_req.entity_handle,
                                              i_req.component_handle};
                                n_fresh         = r_fresh + 1'b1;
                                n_res.result_id = 8'(r_fresh);
                                n_state         = S_DONE;
                            end else begin
                                n_res.status = sid_pkg::STAT_FULL;
                                n_state      = S_DONE;
                            end
                        end
                        sid_pkg::CMD_REMOVE: begin
                            if (MW'(i_req.slot_id) < MW'(r_fresh)) begin
                                slot_re    = 1'b1;
                                slot_raddr = IW'(i_req.slot_id);
                                n_state    = S_REM;
                            end else begin
                                n_res.status = sid_pkg::STAT_MISS;
                                n_state      = S_DONE;
                            end
                        end
                        sid_pkg::CMD_FIND: begin
                            if (r_fresh != '0) begin
                                slot_re    = 1'b1;
                                slot_raddr = '0;
                                n_scan     = '0;
                                n_state    = S_FIND;
                            end else begin
                                n_res.status = sid_pkg::STAT_MISS;
                                n_state      = S_DONE;
                            end
                        end
                        sid_pkg::CMD_CLEAR: begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_count = '0;
                            n_fresh = '0;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_ADDQ: begin
                slot_we    = 1'b1;
                slot_waddr = fq_rdata;
                slot_wdata = {1'b1, r_req.entity_handle, r_req.component_handle};
                if ({1'b0, r_head} == CW'(SLOTS - 1)) begin
                    n_head = '0;
                end else begin
                    n_head = r_head + 1'b1;
                end
                n_count         = r_count - 1'b1;
                n_res.result_id = 8'(fq_rdata);
                n_state         = S_DONE;
            end
            S_REM: begin
                if (slot_rdata.live) begin
                    slot_we    = 1'b1;
                    slot_waddr = IW'(r_req.slot_id);
                    slot_wdata = {1'b0, slot_rdata.entity, slot_rdata.component};
                    fq_we      = 1'b1;
                    if ({1'b0, r_tail} == CW'(SLOTS - 1)) begin
                        n_tail = '0;
                    end else begin
                        n_tail = r_tail + 1'b1;
                    end
                    n_count = r_count + 1'b1;
                end else begin
                    n_res.status = sid_pkg::STAT_MISS;
                end
                n_state = S_DONE;
            end
            S_FIND: begin
                if (slot_rdata.live && (slot_rdata.entity == r_req.entity_handle)) begin
                    n_res.found            = 1'b1;
                    n_res.result_id        = 8'(r_scan);
                    n_res.result_component = slot_rdata.component;
                    n_state                = S_DONE;
                end else if ((CW'(r_scan) + CW'(1)) == r_fresh) begin
                    n_res.status = sid_pkg::STAT_MISS;
                    n_state      = S_DONE;
                end else begin
                    slot_re    = 1'b1;
                    slot_raddr = r_scan + 1'b1;
                    n_scan     = r_scan + 1'b1;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_fresh <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_fresh <= n_fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        r_res  <= n_res;
        if ((r_state == S_IDLE) && i_req_valid) begin
            r_req <= i_req;
        end
    end

endmodule

FILE: hw/rtl/sid_checker.sv
// Port-level checks for the slot ID allocator, attached by a bind statement.
// Depends on sid_pkg and slot_id_allocator_with_lookup.
module sid_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // A held response must not change until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("response changed while stalled");

    // Only one request is in work at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in work");

    // A match is always reported with an ok status.
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |->
            m_axis_tuser[1:0] == sid_pkg::STAT_OK)
        else $error("match flagged with an error status");

    // A failed request carries no ID, no component and no match.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] != sid_pkg::STAT_OK) |->
            (m_axis_tdata == '0) && !m_axis_tuser[2] &&
            (m_axis_tuser[1:0] != 2'd3))
        else $error("failed response carries data");

endmodule

bind slot_id_allocator_with_lookup sid_checker u_sid_checker (.*);
